// ===== hdl/mwad_pkg.sv =====
// ----------------------------------------------------------------------------
// Memory window address decoder package
// Command and region codes, I/O port numbers, select command bytes, reset
// values, address map constants and the window remap function.
// ----------------------------------------------------------------------------
package mwad_pkg;

	typedef enum logic [1:0] {
		CMD_PORT_WR = 2'd0,
		CMD_PORT_RD = 2'd1,
		CMD_CPU_MEM = 2'd2,
		CMD_DMA_MEM = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		RG_RAM      = 4'd0,
		RG_DISP     = 4'd1,
		RG_BIOS     = 4'd2,
		RG_ITF      = 4'd3,
		RG_SOUND    = 4'd4,
		RG_SASI_ROM = 4'd5,
		RG_SASI_RAM = 4'd6,
		RG_SCSI_ROM = 4'd7,
		RG_SCSI_RAM = 4'd8,
		RG_IDE      = 4'd9,
		RG_EMS      = 4'd10,
		RG_NONE     = 4'd11,
		RG_EXP      = 4'd12
	} region_t;

	// I/O ports
	localparam logic [15:0] PORT_DMA_CTRL = 16'h0439;
	localparam logic [15:0] PORT_ITF_SEL  = 16'h043D;
	localparam logic [15:0] PORT_EMS_SEL  = 16'h043F;
	localparam logic [15:0] PORT_WIN_LOW  = 16'h0461;
	localparam logic [15:0] PORT_WIN_HIGH = 16'h0463;
	localparam logic [15:0] PORT_ROM_SEL  = 16'h053D;
	localparam logic [15:0] PORT_RAM_SIZE = 16'h0567;

	// Select command bytes on the ITF and EMS ports
	localparam logic [7:0] ITF_ON_A    = 8'h00;
	localparam logic [7:0] ITF_ON_B    = 8'h10;
	localparam logic [7:0] ITF_ON_C    = 8'h18;
	localparam logic [7:0] ITF_OFF_A   = 8'h02;
	localparam logic [7:0] ITF_OFF_B   = 8'h12;
	localparam logic [7:0] EMS_OFF     = 8'h20;
	localparam logic [7:0] EMS_ON      = 8'h22;
	localparam logic [7:0] OPT_RAM_OFF = 8'hC0;
	localparam logic [7:0] SASI_RAM_EN = 8'hC2;
	localparam logic [7:0] SCSI_RAM_EN = 8'hC4;

	// Reset values
	localparam logic [7:0] RAM_UNITS_RST = 8'h08;
	localparam logic [7:0] DMA_CTRL_RST  = 8'hFE;
	localparam logic [7:0] WIN_LOW_RST   = 8'h08;
	localparam logic [7:0] WIN_HIGH_RST  = 8'h0A;

	// Address map
	localparam int unsigned BIOS_BYTES = 98304;
	localparam int unsigned ITF_BYTES  = 32768;
	localparam logic [31:0] ONE_MEG    = 32'h0010_0000;
	localparam logic [31:0] BIOS_LO    = 32'(ONE_MEG - 32'(BIOS_BYTES));
	localparam logic [31:0] ITF_LO     = 32'(ONE_MEG - 32'(ITF_BYTES));
	localparam logic [31:0] WIN_LOW_LO = 32'h0008_0000;
	localparam logic [31:0] WIN_HI_LO  = 32'h000A_0000;
	localparam logic [31:0] WIN_HI_END = 32'h000C_0000;
	localparam logic [31:0] UPPER_24   = 32'h00FA_0000;
	localparam logic [31:0] UPPER_32   = 32'hFFFA_0000;
	localparam logic [31:0] ADDR_24_END = 32'h0100_0000;

	// Place the low 128 KiB of an address under a window base byte.
	function automatic logic [31:0] windowed(input logic [31:0] a, input logic [7:0] base);
		logic [23:0] r;
		r = {7'h00, a[16:0]} | {base, 16'h0000};
		if (r >= UPPER_24[23:0]) begin
			return {12'h000, r[19:0]};
		end
		return {8'h00, r};
	endfunction

endpackage

// ===== hdl/memory_window_address_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Memory window address decoder
// Holds the bank, window and DMA control registers reached through I/O
// ports, translates CPU and DMA byte addresses and classifies the targets.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | in_valid / in_ready       | cmd, port, wdata, mem_addr
//  result   | out_valid / out_ready     | rdata, phys_addr, on_board,
//           |                           | read_region, write_region
//  config   | cfg_we (no wait)          | cfg_wdata (installed RAM units)
//
//  An item sits in the input register while the decode logic works on it,
//  and the result register loads its result as the item advances.
//  One item is accepted per cycle as long as the result side keeps taking.
//  Port writes update the control registers as the item leaves the input
//  register, so the next item already sees the new values.
//  A stalled result holds both stages; in_ready drops only when both are full.
//  arst_n clears both valid flags and returns all control registers to their
//  power-on values.
//
module memory_window_address_decoder_top
	import mwad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] port,
	input  logic [7:0]  wdata,
	input  logic [31:0] mem_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  rdata,
	output logic [31:0] phys_addr,
	output logic        on_board,
	output logic [3:0]  read_region,
	output logic [3:0]  write_region
);

	// Control registers
	logic [7:0] ram_units_q;
	logic [7:0] dma_ctrl_q;
	logic [7:0] win_low_q;
	logic [7:0] win_high_q;
	logic       itf_on_q;
	logic       bios_ram_q;
	logic       ems_on_q;
	logic [3:0] opt_rom_q;
	logic       sasi_ram_q;
	logic       scsi_ram_q;

	// Input stage
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] port_s1;
	logic [7:0]  wdata_s1;
	logic [31:0] addr_s1;

	// Result stage
	logic        valid_s2;
	logic [7:0]  rdata_s2;
	logic [31:0] phys_s2;
	logic        onb_s2;
	region_t     rd_rg_s2;
	region_t     wr_rg_s2;

	logic adv_s2;
	logic take_s1;

	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign take_s1  = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			cmd_s1   <= cmd_t'(cmd);
			port_s1  <= port;
			wdata_s1 <= wdata;
			addr_s1  <= mem_addr;
		end
	end

	// ------------------------------------------------------------------
	// Address translation
	// ------------------------------------------------------------------
	logic [31:0] addr_in;
	logic        hi_range;
	logic        fold;
	logic        expansion;
	logic [31:0] addr_w;
	logic [31:0] phys_c;

	always_comb begin
		addr_in = addr_s1;
		// DMA address wrap to 20 bits
		if (cmd_s1 == CMD_DMA_MEM && dma_ctrl_q[2]) begin
			addr_in = {12'h000, addr_s1[19:0]};
		end
		hi_range  = addr_in >= UPPER_24;
		// upper aliases fold into the first megabyte and decode again
		fold      = hi_range && (addr_in < ADDR_24_END || addr_in >= UPPER_32);
		expansion = hi_range && !fold;
		addr_w    = fold ? {12'h000, addr_in[19:0]} : addr_in;

		if (expansion || addr_w < WIN_LOW_LO || addr_w >= WIN_HI_END) begin
			phys_c = addr_w;
		end else if (addr_w < WIN_HI_LO) begin
			phys_c = windowed(addr_w, win_low_q);
		end else begin
			phys_c = windowed(addr_w, win_high_q);
		end
	end

	// ------------------------------------------------------------------
	// Region classification
	// ------------------------------------------------------------------
	logic [24:0] ram_top;
	region_t     rd_rg_c;
	region_t     wr_rg_c;
	logic        in_bios_rng;

	assign ram_top = {ram_units_q, 17'h00000};

	always_comb begin
		rd_rg_c     = RG_NONE;
		wr_rg_c     = RG_NONE;
		in_bios_rng = phys_c >= BIOS_LO;
		if (expansion) begin
			rd_rg_c = RG_EXP;
			wr_rg_c = RG_EXP;
		end else if (phys_c < WIN_HI_LO) begin
			rd_rg_c = RG_RAM;
			wr_rg_c = RG_RAM;
		end else if (phys_c >= ONE_MEG) begin
			// extended RAM up to the installed size
			if (phys_c < {7'h00, ram_top}) begin
				rd_rg_c = RG_RAM;
				wr_rg_c = RG_RAM;
			end
		end else if (itf_on_q && phys_c >= ITF_LO) begin
			rd_rg_c = RG_ITF;
		end else if (in_bios_rng) begin
			// ITF hides the rest of the BIOS range; otherwise reads go to BIOS,
			// or to RAM when bios_ram_q is set, and writes go to RAM
			if (!itf_on_q) begin
				rd_rg_c = bios_ram_q ? RG_RAM : RG_BIOS;
				wr_rg_c = RG_RAM;
			end
		end else if (phys_c < 32'h000A_5000
				|| (phys_c >= 32'h000A_8000 && phys_c < 32'h000B_0000)) begin
			rd_rg_c = RG_DISP;
			wr_rg_c = RG_DISP;
		end else if (phys_c >= 32'h000B_0000 && phys_c < WIN_HI_END) begin
			rd_rg_c = ems_on_q ? RG_EMS : RG_DISP;
			wr_rg_c = ems_on_q ? RG_EMS : RG_DISP;
		end else if (phys_c >= 32'h000E_0000 && phys_c < 32'h000E_8000) begin
			rd_rg_c = RG_DISP;
			wr_rg_c = RG_DISP;
		end else if (phys_c >= 32'h000C_C000 && phys_c < 32'h000D_0000) begin
			if (opt_rom_q[3]) begin
				rd_rg_c = RG_SOUND;
			end
		end else if (phys_c >= 32'h000D_7000 && phys_c < 32'h000D_8000) begin
			if (opt_rom_q[2]) begin
				if (sasi_ram_q) begin
					rd_rg_c = RG_SASI_RAM;
					wr_rg_c = RG_SASI_RAM;
				end else begin
					rd_rg_c = RG_SASI_ROM;
				end
			end
		end else if (phys_c >= 32'h000D_8000 && phys_c < 32'h000D_C000) begin
			if (opt_rom_q[0]) begin
				rd_rg_c = RG_IDE;
			end
		end else if (phys_c >= 32'h000D_C000 && phys_c < 32'h000D_D000) begin
			if (opt_rom_q[1]) begin
				if (scsi_ram_q) begin
					rd_rg_c = RG_SCSI_RAM;
					wr_rg_c = RG_SCSI_RAM;
				end else begin
					rd_rg_c = RG_SCSI_ROM;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Port read mux
	// ------------------------------------------------------------------
	logic [7:0] port_rd_c;

	always_comb begin
		case (port_s1)
			PORT_DMA_CTRL: port_rd_c = dma_ctrl_q;
			PORT_WIN_LOW:  port_rd_c = win_low_q;
			PORT_WIN_HIGH: port_rd_c = win_high_q;
			PORT_RAM_SIZE: port_rd_c = ram_units_q;
			default:       port_rd_c = 8'hFF;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers: updated by port writes as the item advances, RAM units by cfg_we
	// ------------------------------------------------------------------
	logic port_wr;

	assign port_wr = adv_s2 && cmd_s1 == CMD_PORT_WR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_units_q <= RAM_UNITS_RST;
		end else if (cfg_we) begin
			ram_units_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_ctrl_q <= DMA_CTRL_RST;
			win_low_q  <= WIN_LOW_RST;
			win_high_q <= WIN_HIGH_RST;
			itf_on_q   <= 1'b1;
			bios_ram_q <= 1'b0;
			ems_on_q   <= 1'b0;
			opt_rom_q  <= 4'h0;
			sasi_ram_q <= 1'b0;
			scsi_ram_q <= 1'b0;
		end else if (port_wr) begin
			case (port_s1)
				PORT_ITF_SEL: begin
					if (wdata_s1 == ITF_ON_A || wdata_s1 == ITF_ON_B
							|| wdata_s1 == ITF_ON_C) begin
						itf_on_q <= 1'b1;
					end else if (wdata_s1 == ITF_OFF_A || wdata_s1 == ITF_OFF_B) begin
						itf_on_q <= 1'b0;
					end
				end
				PORT_EMS_SEL: begin
					case (wdata_s1)
						EMS_OFF: ems_on_q <= 1'b0;
						EMS_ON:  ems_on_q <= 1'b1;
						OPT_RAM_OFF: begin
							sasi_ram_q <= 1'b0;
							scsi_ram_q <= 1'b0;
						end
						SASI_RAM_EN: sasi_ram_q <= 1'b1;
						SCSI_RAM_EN: scsi_ram_q <= 1'b1;
						default: ;
					endcase
				end
				PORT_DMA_CTRL: dma_ctrl_q <= wdata_s1;
				// window bases are 128 KiB aligned
				PORT_WIN_LOW:  win_low_q  <= {wdata_s1[7:1], 1'b0};
				PORT_WIN_HIGH: win_high_q <= {wdata_s1[7:1], 1'b0};
				PORT_ROM_SEL: begin
					opt_rom_q  <= wdata_s1[7:4];
					bios_ram_q <= wdata_s1[1];
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			case (cmd_s1)
				CMD_PORT_WR: begin
					rdata_s2 <= 8'h00;
					phys_s2  <= 32'h0;
					onb_s2   <= 1'b0;
					rd_rg_s2 <= RG_RAM;
					wr_rg_s2 <= RG_RAM;
				end
				CMD_PORT_RD: begin
					rdata_s2 <= port_rd_c;
					phys_s2  <= 32'h0;
					onb_s2   <= 1'b0;
					rd_rg_s2 <= RG_RAM;
					wr_rg_s2 <= RG_RAM;
				end
				default: begin
					rdata_s2 <= 8'h00;
					phys_s2  <= phys_c;
					onb_s2   <= !expansion;
					rd_rg_s2 <= rd_rg_c;
					wr_rg_s2 <= wr_rg_c;
				end
			endcase
		end
	end

	assign out_valid    = valid_s2;
	assign rdata        = rdata_s2;
	assign phys_addr    = phys_s2;
	assign on_board     = onb_s2;
	assign read_region  = 4'(rd_rg_s2);
	assign write_region = 4'(wr_rg_s2);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled while a stage is free");

	a_win_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		!win_low_q[0] && !win_high_q[0])
		else $error("window base not 128 KiB aligned");

	a_offboard_is_exp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !onb_s2 && phys_s2 != 32'h0 |->
			rd_rg_s2 == RG_EXP && wr_rg_s2 == RG_EXP && rdata_s2 == 8'h00)
		else $error("expansion access with wrong regions");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(phys_s2) && $stable(rdata_s2))
		else $error("stalled result changed");

endmodule
